// ----- design/ascii_decimal_number_parser_unit_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the ASCII decimal number parser
// Concurrent checks on the clock and reset of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef ASCII_DECIMAL_NUMBER_PARSER_UNIT_ASSERT_SVH
`define ASCII_DECIMAL_NUMBER_PARSER_UNIT_ASSERT_SVH

`ifndef SYNTH

`define ADNP_ASSERT_SAME_CYCLE(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (expr)) \
      else $error("parser check failed in the same cycle");

`define ADNP_ASSERT_NEXT_CYCLE(label, cond, expr) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (expr)) \
      else $error("parser check failed in the following cycle");

`else

`define ADNP_ASSERT_SAME_CYCLE(label, cond, expr)

`define ADNP_ASSERT_NEXT_CYCLE(label, cond, expr)

`endif

`endif

// ----- design/adnp_pkg.sv -----
// ----------------------------------------------------------------------------
// ASCII decimal number parser package
// Payload types, character codes and fixed-point constants.
// ----------------------------------------------------------------------------
package adnp_pkg;

   localparam int INT_BITS          = 31;
   localparam int VALUE_BITS        = 48;
   localparam int DIGIT_COUNT_BITS  = 4;
   localparam int FRAC_BITS_DEFAULT   = 16;
   localparam int WEIGHT_BITS_DEFAULT = 32;

   localparam logic [INT_BITS-1:0]   INT_MAX   = '1;
   localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};

   localparam logic [7:0] CHAR_ZERO  = 8'd48;
   localparam logic [7:0] CHAR_NINE  = 8'd57;
   localparam logic [7:0] CHAR_MINUS = 8'd45;
   localparam logic [7:0] CHAR_POINT = 8'd46;
   localparam logic [7:0] CHAR_COMMA = 8'd44;

   typedef struct packed {
      logic [7:0] char_code;
      logic       last_char;
   } req_payload_type;

   typedef struct packed {
      logic signed [VALUE_BITS-1:0] value;
      logic                         bad_string;
      logic                         overflowed;
   } rsp_payload_type;

   // Summary of a finished string, handed from the accumulator to the formatter.
   typedef struct packed {
      logic minus;
      logic bad;
      logic saturated;
      logic integer_mode;
   } string_flags_type;

endpackage

// ----- design/adnp_accum.sv -----
// ----------------------------------------------------------------------------
// ASCII decimal number parser: character accumulator
// Holds the per-string state and folds in one character per cycle on step_go.
// ----------------------------------------------------------------------------
module adnp_accum #(
   parameter int WEIGHT_BITS = adnp_pkg::WEIGHT_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step_go,
   input  logic [7:0]                     char_code,
   input  logic                           last_char,
   input  logic                           integer_mode,
   output adnp_pkg::string_flags_type     done_flags,
   output logic [adnp_pkg::INT_BITS-1:0]  done_int,
   output logic [WEIGHT_BITS-1:0]         done_frac
);
   import adnp_pkg::*;

   localparam int WEIGHT_DEPTH = 1 << DIGIT_COUNT_BITS;
   localparam int INT_WIDE     = INT_BITS + 4;
   localparam int FRAC_WIDE    = WEIGHT_BITS + 4;

   // Digit weights, one tenth and then each rounded tenth of the one before.
   function automatic logic [WEIGHT_DEPTH*WEIGHT_BITS-1:0] build_weights();
      logic [WEIGHT_DEPTH*WEIGHT_BITS-1:0] rom;
      logic [WEIGHT_BITS:0]                w;
      rom = '0;
      w   = ((WEIGHT_BITS+1)'(1) << WEIGHT_BITS) + (WEIGHT_BITS+1)'(5);
      w   = w / 10;
      for (int k = 0; k < WEIGHT_DEPTH; k++) begin
         rom[k*WEIGHT_BITS +: WEIGHT_BITS] = w[WEIGHT_BITS-1:0];
         w = (w + (WEIGHT_BITS+1)'(5)) / 10;
      end
      return rom;
   endfunction

   localparam logic [WEIGHT_DEPTH*WEIGHT_BITS-1:0] WEIGHT_ROM = build_weights();

   logic [INT_BITS-1:0]         int_ff, int_in;
   logic [WEIGHT_BITS-1:0]      frac_ff, frac_in;
   logic [DIGIT_COUNT_BITS-1:0] count_ff, count_in;
   logic                        minus_ff, minus_in;
   logic                        point_ff, point_in;
   logic                        bad_ff, bad_in;
   logic                        sat_ff, sat_in;

   logic [3:0]             digit;
   logic [WEIGHT_BITS-1:0] weight;
   logic [INT_WIDE-1:0]    int_wide;
   logic [FRAC_WIDE-1:0]   frac_wide;

   always_comb begin
      digit     = 4'(char_code - CHAR_ZERO);
      weight    = WEIGHT_ROM[count_ff*WEIGHT_BITS +: WEIGHT_BITS];
      int_wide  = (INT_WIDE'(int_ff) << 3) + (INT_WIDE'(int_ff) << 1) + INT_WIDE'(digit);
      frac_wide = FRAC_WIDE'(frac_ff) + FRAC_WIDE'(digit) * FRAC_WIDE'(weight);

      int_in   = int_ff;
      frac_in  = frac_ff;
      count_in = count_ff;
      minus_in = minus_ff;
      point_in = point_ff;
      bad_in   = bad_ff;
      sat_in   = sat_ff;

      // Once the string is bad, every further character is ignored.
      if (!bad_ff) begin
         priority if (char_code >= CHAR_ZERO && char_code <= CHAR_NINE) begin
            if (point_ff && !integer_mode) begin
               frac_in = (|frac_wide[FRAC_WIDE-1:WEIGHT_BITS]) ? '1
                                                              : frac_wide[WEIGHT_BITS-1:0];
               if (count_ff != '1) begin
                  count_in = count_ff + 1'b1;
               end
            end else begin
               if (|int_wide[INT_WIDE-1:INT_BITS]) begin
                  int_in = INT_MAX;
                  sat_in = 1'b1;
               end else begin
                  int_in = int_wide[INT_BITS-1:0];
               end
            end
         end else if (char_code == CHAR_MINUS) begin
            minus_in = 1'b1;
            bad_in   = minus_ff;
         end else if (char_code == CHAR_POINT || char_code == CHAR_COMMA) begin
            point_in = 1'b1;
            bad_in   = point_ff;
         end else begin
            bad_in = 1'b1;
         end
      end
   end

   assign done_int                = int_in;
   assign done_frac               = frac_in;
   assign done_flags.minus        = minus_in;
   assign done_flags.bad          = bad_in;
   assign done_flags.saturated    = sat_in;
   assign done_flags.integer_mode = integer_mode;

   always_ff @(posedge clock) begin
      if (reset || (step_go && last_char)) begin
         int_ff   <= '0;
         frac_ff  <= '0;
         count_ff <= '0;
         minus_ff <= 1'b0;
         point_ff <= 1'b0;
         bad_ff   <= 1'b0;
         sat_ff   <= 1'b0;
      end else if (step_go) begin
         int_ff   <= int_in;
         frac_ff  <= frac_in;
         count_ff <= count_in;
         minus_ff <= minus_in;
         point_ff <= point_in;
         bad_ff   <= bad_in;
         sat_ff   <= sat_in;
      end
   end

endmodule

// ----- design/adnp_format.sv -----
// ----------------------------------------------------------------------------
// ASCII decimal number parser: result formatter
// Builds the signed result from the totals of a finished string.
// ----------------------------------------------------------------------------
module adnp_format #(
   parameter int FRAC_BITS   = adnp_pkg::FRAC_BITS_DEFAULT,
   parameter int WEIGHT_BITS = adnp_pkg::WEIGHT_BITS_DEFAULT
) (
   input  adnp_pkg::string_flags_type    flags,
   input  logic [adnp_pkg::INT_BITS-1:0] int_total,
   input  logic [WEIGHT_BITS-1:0]        frac_total,
   output adnp_pkg::rsp_payload_type     result
);
   import adnp_pkg::*;

   localparam int MAG_BITS = INT_BITS + FRAC_BITS + 1;
   localparam int EXT_BITS = (MAG_BITS > VALUE_BITS) ? MAG_BITS : VALUE_BITS;

   logic [MAG_BITS-1:0]   fixed_mag;
   logic [EXT_BITS-1:0]   fixed_ext;
   logic                  fixed_big;
   logic [VALUE_BITS-1:0] magnitude;
   logic                  over;

   generate
      if (WEIGHT_BITS > FRAC_BITS) begin : g_round
         localparam int SHIFT    = WEIGHT_BITS - FRAC_BITS;
         localparam int SUM_BITS = INT_BITS + WEIGHT_BITS + 1;
         localparam logic [SUM_BITS-1:0] HALF = SUM_BITS'(1) << (SHIFT - 1);
         logic [SUM_BITS-1:0] wide;
         // Integer and fraction are added at full weight precision, then
         // rounded half up to the kept fraction bits.
         assign wide      = SUM_BITS'({int_total, frac_total}) + HALF;
         assign fixed_mag = wide[SUM_BITS-1:SHIFT];
      end else begin : g_widen
         assign fixed_mag = MAG_BITS'({int_total, frac_total}) << (FRAC_BITS - WEIGHT_BITS);
      end
   endgenerate

   always_comb begin
      fixed_ext = EXT_BITS'(fixed_mag);
      fixed_big = |fixed_ext[EXT_BITS-1:VALUE_BITS-1];
      if (flags.integer_mode) begin
         magnitude = VALUE_BITS'(int_total);
         over      = flags.saturated;
      end else begin
         magnitude = fixed_big ? VALUE_MAX : fixed_ext[VALUE_BITS-1:0];
         over      = flags.saturated || fixed_big;
      end

      if (flags.bad) begin
         result.value      = '0;
         result.bad_string = 1'b1;
         result.overflowed = 1'b0;
      end else begin
         result.value      = flags.minus ? -$signed(magnitude) : $signed(magnitude);
         result.bad_string = 1'b0;
         result.overflowed = over;
      end
   end

endmodule

// ----- design/ascii_decimal_number_parser_unit.sv -----
// ----------------------------------------------------------------------------
// ASCII decimal number parser unit
// Parses a stream of ASCII characters into a signed fixed-point or integer
// number, one result for each string closed by a last character.
//
//   Channel   Direction  Handshake                     Payload
//   req_      in         req_valid / req_stall         char_code, last_char
//   rsp_      out        rsp_valid / rsp_stall         value, bad_string, overflowed
//   csr_      in         csr_write_enable              integer_mode
//
// One character is taken every cycle unless a last character waits for room;
// the update of the string state (digit times weight added to the fraction,
// times ten for the integer) sets that rate. A string's totals pass the
// finished-string register and then the result register. Reset is synchronous
// and clears the string state and the mode. While the result register is
// stalled, characters are taken until a last character meets a full queue.
// ----------------------------------------------------------------------------
module ascii_decimal_number_parser_unit #(
   parameter int FRAC_BITS   = adnp_pkg::FRAC_BITS_DEFAULT,
   parameter int WEIGHT_BITS = adnp_pkg::WEIGHT_BITS_DEFAULT
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  adnp_pkg::req_payload_type req_payload,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output adnp_pkg::rsp_payload_type rsp_payload,
   input  logic                      csr_write_enable,
   input  logic                      csr_write_data
);
   import adnp_pkg::*;

   logic mode_ff;

   logic            in_valid_ff, in_valid_in;
   req_payload_type in_payload_ff;

   logic                   fin_valid_ff, fin_valid_in;
   string_flags_type       fin_flags_ff;
   logic [INT_BITS-1:0]    fin_int_ff;
   logic [WEIGHT_BITS-1:0] fin_frac_ff;

   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_payload_ff, rsp_payload_in;

   string_flags_type       done_flags;
   logic [INT_BITS-1:0]    done_int;
   logic [WEIGHT_BITS-1:0] done_frac;

   logic out_free, fin_free, step_go, in_free, req_take, fin_load, out_load;

   always_comb begin
      out_free = !rsp_valid_ff || !rsp_stall;
      out_load = fin_valid_ff && out_free;
      fin_free = !fin_valid_ff || out_free;
      // A plain character never waits; a last character needs room downstream.
      step_go  = in_valid_ff && (!in_payload_ff.last_char || fin_free);
      fin_load = step_go && in_payload_ff.last_char;
      in_free  = !in_valid_ff || step_go;
      req_take = req_valid && in_free;

      in_valid_in  = req_take || (in_valid_ff && !step_go);
      fin_valid_in = fin_load || (fin_valid_ff && !out_load);
      rsp_valid_in = out_load || (rsp_valid_ff && rsp_stall);
   end

   assign req_stall   = !in_free;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   adnp_accum #(
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_accum (
      .clock        (clock),
      .reset        (reset),
      .step_go      (step_go),
      .char_code    (in_payload_ff.char_code),
      .last_char    (in_payload_ff.last_char),
      .integer_mode (mode_ff),
      .done_flags   (done_flags),
      .done_int     (done_int),
      .done_frac    (done_frac)
   );

   adnp_format #(
      .FRAC_BITS   (FRAC_BITS),
      .WEIGHT_BITS (WEIGHT_BITS)
   ) u_format (
      .flags      (fin_flags_ff),
      .int_total  (fin_int_ff),
      .frac_total (fin_frac_ff),
      .result     (rsp_payload_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            mode_ff <= csr_write_data;
         end
         in_valid_ff  <= in_valid_in;
         fin_valid_ff <= fin_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_payload_ff <= req_payload;
      end
      if (fin_load) begin
         fin_flags_ff <= done_flags;
         fin_int_ff   <= done_int;
         fin_frac_ff  <= done_frac;
      end
      if (out_load) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

`include "ascii_decimal_number_parser_unit_assert.svh"

   // Back-pressure reaches the request side only with a finished string queued.
   `ADNP_ASSERT_SAME_CYCLE(a_stall_needs_full_queue, req_stall, in_valid_ff && in_payload_ff.last_char && fin_valid_ff)
   // A finished string is kept while the result register cannot take it.
   `ADNP_ASSERT_NEXT_CYCLE(a_finished_string_held, fin_valid_ff && rsp_valid_ff && rsp_stall, fin_valid_ff)
   // A bad string always reports zero with no overflow.
   `ADNP_ASSERT_SAME_CYCLE(a_bad_string_is_zero, rsp_valid_ff && rsp_payload_ff.bad_string, rsp_payload_ff.value == '0 && !rsp_payload_ff.overflowed)
   // A plain character never produces a finished string.
   `ADNP_ASSERT_NEXT_CYCLE(a_plain_char_no_result, in_valid_ff && !in_payload_ff.last_char && !fin_valid_ff, !fin_valid_ff)

endmodule
